/* src/est_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_pkg
// Shared types, constants and helpers for the sensor trim compensation pipe.
// ----------------------------------------------------------------------------
package est_pkg;

    typedef logic [31:0] t_w32;

    typedef enum logic [2:0] {
        REG_TEMP_TRIM  = 3'd0,
        REG_PRESS_LO   = 3'd1,
        REG_PRESS_HI   = 3'd2,
        REG_PRESS_NINE = 3'd3,
        REG_HUM_TRIM   = 3'd4
    } t_reg_idx;

    localparam int P_DIV_BITS = 32;
    // S1..S12, divider load plus one stage per quotient bit, two post stages
    localparam int P_DEPTH    = 12 + P_DIV_BITS + 1 + 2;

    localparam t_w32 C_P_OFS   = 32'd64000;
    localparam t_w32 C_P_BASE  = 32'd1048576;
    localparam t_w32 C_P_SCALE = 32'd3125;
    localparam t_w32 C_H_OFS   = 32'd76800;
    localparam t_w32 C_H_MAX   = 32'd419430400;
    localparam t_w32 C_H_RND   = 32'd16384;
    localparam t_w32 C_H_BIAS  = 32'd2097152;
    localparam t_w32 C_H_RND2  = 32'd8192;
    localparam t_w32 C_HALF    = 32'd32768;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] fine;
        logic [16:0] hum;
        logic        dbl;
    } t_dvp;

    function automatic t_w32 asr(input t_w32 x, input int n);
        return t_w32'($signed(x) >>> n);
    endfunction

endpackage

/* src/env_sensor_trim_compensation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// env_sensor_trim_compensation
// Throughput: one request per cycle; the whole pipe advances together and
// holds when the output register is full and not taken.
// Most of the depth comes from the 32 one-bit stages of the pressure divider.
// Reset clears the stage valid bits and trim registers; payload is not reset.
// ----------------------------------------------------------------------------
module env_sensor_trim_compensation (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
    input  logic [55:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // temp_centideg[31:0], fine_temp[63:32], pressure_pa[95:64],
    // humidity_q10[112:96], zero fill above
    output logic [119:0] o_m_axis_tdata
);

    localparam int D = est_pkg::P_DIV_BITS;

    logic [47:0] r_temp_trim;
    logic [63:0] r_plo, r_phi, r_hum_trim;
    logic [15:0] r_p9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim <= '0;
            r_plo       <= '0;
            r_phi       <= '0;
            r_p9        <= '0;
            r_hum_trim  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                est_pkg::REG_TEMP_TRIM:  r_temp_trim <= i_cfg_data[47:0];
                est_pkg::REG_PRESS_LO:   r_plo       <= i_cfg_data;
                est_pkg::REG_PRESS_HI:   r_phi       <= i_cfg_data;
                est_pkg::REG_PRESS_NINE: r_p9        <= i_cfg_data[15:0];
                est_pkg::REG_HUM_TRIM:   r_hum_trim  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    est_pkg::t_w32 t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    est_pkg::t_w32 h1, h2, h3, h4, h5, h6;

    assign t1 = {16'b0, r_temp_trim[15:0]};
    assign t2 = {{16{r_temp_trim[31]}}, r_temp_trim[31:16]};
    assign t3 = {{16{r_temp_trim[47]}}, r_temp_trim[47:32]};
    assign p1 = {16'b0, r_plo[15:0]};
    assign p2 = {{16{r_plo[31]}}, r_plo[31:16]};
    assign p3 = {{16{r_plo[47]}}, r_plo[47:32]};
    assign p4 = {{16{r_plo[63]}}, r_plo[63:48]};
    assign p5 = {{16{r_phi[15]}}, r_phi[15:0]};
    assign p6 = {{16{r_phi[31]}}, r_phi[31:16]};
    assign p7 = {{16{r_phi[47]}}, r_phi[47:32]};
    assign p8 = {{16{r_phi[63]}}, r_phi[63:48]};
    assign p9 = {{16{r_p9[15]}}, r_p9};
    assign h1 = {24'b0, r_hum_trim[7:0]};
    assign h2 = {{16{r_hum_trim[23]}}, r_hum_trim[23:8]};
    assign h3 = {24'b0, r_hum_trim[31:24]};
    assign h4 = {{20{r_hum_trim[43]}}, r_hum_trim[43:32]};
    assign h5 = {{20{r_hum_trim[55]}}, r_hum_trim[55:44]};
    assign h6 = {{24{r_hum_trim[63]}}, r_hum_trim[63:56]};

    logic en;
    logic [est_pkg::P_DEPTH-1:0] r_vld;
    logic r_ov;

    assign en              = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r_vld <= {r_vld[est_pkg::P_DEPTH-2:0], i_s_axis_tvalid};
            r_ov  <= r_vld[est_pkg::P_DEPTH-1];
        end
    end

    est_pkg::t_w32 adc_t, adc_p, adc_h;
    assign adc_t = {12'b0, i_s_axis_tdata[19:0]};
    assign adc_p = {12'b0, i_s_axis_tdata[39:20]};
    assign adc_h = {16'b0, i_s_axis_tdata[55:40]};

    est_pkg::t_w32 r1_ma, r1_mb, r1_p, r1_h;
    est_pkg::t_w32 r2_at, r2_m, r2_p, r2_h;
    est_pkg::t_w32 r3_fine, r3_p, r3_h;
    est_pkg::t_w32 r4_fine, r4_temp, r4_pa, r4_ha, r4_p, r4_h;
    est_pkg::t_w32 r5_fine, r5_temp, r5_d, r5_p5, r5_p2, r5_hm, r5_h6, r5_h3, r5_p, r5_h;
    est_pkg::t_w32 r6_fine, r6_temp, r6_b, r6_m, r6_p5, r6_p2, r6_hb, r6_hd, r6_hx, r6_p;
    est_pkg::t_w32 r7_fine, r7_temp, r7_b, r7_a, r7_hd, r7_hb, r7_p;
    est_pkg::t_w32 r8_fine, r8_temp, r8_am, r8_b, r8_hm, r8_hb, r8_p;
    est_pkg::t_w32 r9_fine, r9_temp, r9_div, r9_pn, r9_hd, r9_hb;
    est_pkg::t_w32 r10_fine, r10_temp, r10_ha, r10_num, r10_div;
    logic          r10_dbl;
    est_pkg::t_w32 r11_fine, r11_temp, r11_ha, r11_hq, r11_num, r11_div;
    logic          r11_dbl;
    est_pkg::t_w32 r12_fine, r12_temp, r12_ha, r12_hq, r12_num, r12_div;
    logic          r12_dbl;

    est_pkg::t_w32 n_bb, n_q, n_hb2, n_ha;
    est_pkg::t_w32 n_hcl;

    always_comb begin
        n_q   = est_pkg::asr(r4_pa, 2);
        n_bb  = r6_b + (r6_p5 << 1);
        n_hb2 = est_pkg::asr(r10_ha, 15);
        n_ha  = r12_ha - est_pkg::asr(r12_hq, 4);
        if (n_ha[31]) begin
            n_hcl = '0;
        end else if (n_ha > est_pkg::C_H_MAX) begin
            n_hcl = est_pkg::C_H_MAX;
        end else begin
            n_hcl = n_ha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ma <= ((adc_t >> 3) - (t1 << 1)) * t2;
            r1_mb <= ((adc_t >> 4) - t1) * ((adc_t >> 4) - t1);
            r1_p  <= adc_p;
            r1_h  <= adc_h;

            r2_at <= est_pkg::asr(r1_ma, 11);
            r2_m  <= est_pkg::asr(r1_mb, 12) * t3;
            r2_p  <= r1_p;
            r2_h  <= r1_h;

            r3_fine <= r2_at + est_pkg::asr(r2_m, 14);
            r3_p    <= r2_p;
            r3_h    <= r2_h;

            r4_fine <= r3_fine;
            r4_temp <= est_pkg::asr((r3_fine << 2) + r3_fine + 32'd128, 8);
            r4_pa   <= est_pkg::asr(r3_fine, 1) - est_pkg::C_P_OFS;
            r4_ha   <= r3_fine - est_pkg::C_H_OFS;
            r4_p    <= r3_p;
            r4_h    <= r3_h;

            r5_fine <= r4_fine;
            r5_temp <= r4_temp;
            r5_d    <= n_q * n_q;
            r5_p5   <= r4_pa * p5;
            r5_p2   <= p2 * r4_pa;
            r5_hm   <= h5 * r4_ha;
            r5_h6   <= r4_ha * h6;
            r5_h3   <= r4_ha * h3;
            r5_p    <= r4_p;
            r5_h    <= r4_h;

            r6_fine <= r5_fine;
            r6_temp <= r5_temp;
            r6_b    <= est_pkg::asr(r5_d, 11) * p6;
            r6_m    <= p3 * est_pkg::asr(r5_d, 13);
            r6_p5   <= r5_p5;
            r6_p2   <= r5_p2;
            r6_hb   <= est_pkg::asr((r5_h << 14) - (h4 << 20) - r5_hm + est_pkg::C_H_RND, 15);
            r6_hd   <= est_pkg::asr(r5_h6, 10);
            r6_hx   <= est_pkg::asr(r5_h3, 11) + est_pkg::C_HALF;
            r6_p    <= r5_p;

            r7_fine <= r6_fine;
            r7_temp <= r6_temp;
            r7_b    <= est_pkg::asr(n_bb, 2) + (p4 << 16);
            r7_a    <= est_pkg::asr(est_pkg::asr(r6_m, 3) + est_pkg::asr(r6_p2, 1), 18);
            r7_hd   <= r6_hd * r6_hx;
            r7_hb   <= r6_hb;
            r7_p    <= r6_p;

            r8_fine <= r7_fine;
            r8_temp <= r7_temp;
            r8_am   <= (est_pkg::C_HALF + r7_a) * p1;
            r8_b    <= r7_b;
            r8_hm   <= (est_pkg::asr(r7_hd, 10) + est_pkg::C_H_BIAS) * h2;
            r8_hb   <= r7_hb;
            r8_p    <= r7_p;

            r9_fine <= r8_fine;
            r9_temp <= r8_temp;
            r9_div  <= est_pkg::asr(r8_am, 15);
            r9_pn   <= ((est_pkg::C_P_BASE - r8_p) - est_pkg::asr(r8_b, 12)) * est_pkg::C_P_SCALE;
            r9_hd   <= est_pkg::asr(r8_hm + est_pkg::C_H_RND2, 14);
            r9_hb   <= r8_hb;

            r10_fine <= r9_fine;
            r10_temp <= r9_temp;
            r10_ha   <= r9_hb * r9_hd;
            r10_num  <= r9_pn[31] ? r9_pn : (r9_pn << 1);
            r10_dbl  <= r9_pn[31];
            r10_div  <= r9_div;

            r11_fine <= r10_fine;
            r11_temp <= r10_temp;
            r11_ha   <= r10_ha;
            r11_hq   <= n_hb2 * n_hb2;
            r11_num  <= r10_num;
            r11_div  <= r10_div;
            r11_dbl  <= r10_dbl;

            r12_fine <= r11_fine;
            r12_temp <= r11_temp;
            r12_ha   <= r11_ha;
            r12_hq   <= est_pkg::asr(r11_hq, 7) * h1;
            r12_num  <= r11_num;
            r12_div  <= r11_div;
            r12_dbl  <= r11_dbl;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [31:0]  r_dv_num [0:D];
    logic [31:0]  r_dv_rem [0:D];
    logic [31:0]  r_dv_quo [0:D];
    logic [31:0]  r_dv_den [0:D];
    est_pkg::t_dvp r_dv_pay [0:D];

    logic [32:0] n_trial [0:D-1];
    logic [32:0] n_diff  [0:D-1];

    always_comb begin
        for (int k = 0; k < D; k++) begin
            n_trial[k] = {r_dv_rem[k], r_dv_num[k][31]};
            n_diff[k]  = n_trial[k] - {1'b0, r_dv_den[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_num[0]      <= r12_num;
            r_dv_rem[0]      <= '0;
            r_dv_quo[0]      <= '0;
            r_dv_den[0]      <= r12_div;
            r_dv_pay[0].temp <= r12_temp;
            r_dv_pay[0].fine <= r12_fine;
            r_dv_pay[0].hum  <= n_hcl[28:12];
            r_dv_pay[0].dbl  <= r12_dbl;
            for (int k = 0; k < D; k++) begin
                r_dv_num[k+1] <= r_dv_num[k] << 1;
                r_dv_den[k+1] <= r_dv_den[k];
                r_dv_pay[k+1] <= r_dv_pay[k];
                if (!n_diff[k][32]) begin
                    r_dv_rem[k+1] <= n_diff[k][31:0];
                    r_dv_quo[k+1] <= {r_dv_quo[k][30:0], 1'b1};
                end else begin
                    r_dv_rem[k+1] <= n_trial[k][31:0];
                    r_dv_quo[k+1] <= {r_dv_quo[k][30:0], 1'b0};
                end
            end
        end
    end

    est_pkg::t_w32 n_pr;
    est_pkg::t_w32 r_q1_pr, r_q1_mq, r_q1_mb, r_q2_pr, r_q2_ma, r_q2_mb;
    est_pkg::t_dvp r_q1_pay, r_q2_pay;
    logic          r_q1_zero, r_q2_zero;
    est_pkg::t_w32 r_o_temp, r_o_fine, r_o_press;
    logic [16:0]   r_o_hum;

    assign n_pr = r_dv_pay[D].dbl ? (r_dv_quo[D] << 1) : r_dv_quo[D];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1_pr   <= n_pr;
            r_q1_mq   <= (n_pr >> 3) * (n_pr >> 3);
            r_q1_mb   <= (n_pr >> 2) * p8;
            r_q1_pay  <= r_dv_pay[D];
            r_q1_zero <= (r_dv_den[D] == '0);

            r_q2_pr   <= r_q1_pr;
            r_q2_ma   <= (r_q1_mq >> 13) * p9;
            r_q2_mb   <= r_q1_mb;
            r_q2_pay  <= r_q1_pay;
            r_q2_zero <= r_q1_zero;

            r_o_temp  <= r_q2_pay.temp;
            r_o_fine  <= r_q2_pay.fine;
            r_o_hum   <= r_q2_pay.hum;
            r_o_press <= r_q2_zero ? '0 :
                r_q2_pr + est_pkg::asr(est_pkg::asr(r_q2_ma, 12)
                                       + est_pkg::asr(r_q2_mb, 13) + p7, 4);
        end
    end

    assign o_m_axis_tdata = {7'b0, r_o_hum, r_o_press, r_o_fine, r_o_temp};

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[112:96] <= 17'd102400))
        else $error("humidity out of range");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == !(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input ready does not follow output stall");

    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_zero_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_q2_zero) |=> (o_m_axis_tdata[95:64] == 32'd0))
        else $error("pressure not zero for zero divisor");

endmodule
